// ===== sv/cmr_pkg.sv =====
// ----------------------------------------------------------------------------
// cmr_pkg
// shared types and constants for channel mean removal
// ----------------------------------------------------------------------------
package cmr_pkg;

  localparam int MAX_CHANNELS_DEF = 64;
  localparam int MAX_FRAMES_DEF   = 1024;
  localparam int SAMPLE_BITS_DEF  = 24;

  localparam int CMD_W      = 2;
  localparam int CH_FIELD_W = 6;
  localparam int CFG_W      = 7;

  localparam logic [CFG_W-1:0] CHANNELS_RESET = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_ACC    = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_SUB,
    S_FRD,
    S_FSTART,
    S_FDIV
  } state_t;

  typedef struct packed {
    logic accept;
    logic clr;
    logic frame_inc;
    logic freeze;
    logic acc_wr;
    logic k_clr;
    logic fin_rd;
    logic div_start;
    logic mean_wr;
    logic k_inc;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic in_active;
    logic frozen;
    logic fc_full;
    logic ch_zero;
    logic div_done;
    logic last_ch;
  } st_t;

endpackage

// ===== sv/cmr_div.sv =====
// ----------------------------------------------------------------------------
// cmr_div
// iterative restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module cmr_div #(
  parameter int NUM_W = 35,
  parameter int DEN_W = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] q_r;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign rem_sh = {rem_r, q_r[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};
  assign diff   = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      q_r   <= {q_r[NUM_W-2:0], ge};
      rem_r <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// ===== sv/cmr_ctrl.sv =====
// ----------------------------------------------------------------------------
// cmr_ctrl
// command sequencer and output handshake for channel mean removal
// ----------------------------------------------------------------------------
module cmr_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [cmr_pkg::CMD_W-1:0]      in_cmd,
  output logic                           in_ready,
  input  logic                           out_ready,
  output logic                           out_valid,
  input  cmr_pkg::st_t                   st,
  output cmr_pkg::ctl_t                  ctl
);
  import cmr_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.accept = 1'b1;
          unique case (cmd_t'(in_cmd))
            CMD_CLEAR: begin
              ctl.clr = 1'b1;
            end
            CMD_ACC: begin
              if (st.in_active && !st.frozen) begin
                if (st.ch_zero && st.fc_full) begin
                  ctl.freeze = 1'b1;
                end else begin
                  ctl.frame_inc = st.ch_zero;
                  state_nxt     = S_ACC;
                end
              end
            end
            CMD_FINISH: begin
              ctl.k_clr = 1'b1;
              state_nxt = S_FRD;
            end
            CMD_REMOVE: begin
              if (st.in_active) state_nxt = S_SUB;
            end
            default: ;
          endcase
        end
      end
      S_ACC: begin
        ctl.acc_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_SUB: begin
        if (!out_valid_r || out_ready) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_FRD: begin
        ctl.fin_rd = 1'b1;
        state_nxt  = S_FSTART;
      end
      S_FSTART: begin
        ctl.div_start = 1'b1;
        state_nxt     = S_FDIV;
      end
      S_FDIV: begin
        if (st.div_done) begin
          ctl.mean_wr = 1'b1;
          if (st.last_ch) begin
            state_nxt = S_IDLE;
          end else begin
            ctl.k_inc = 1'b1;
            state_nxt = S_FRD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (ctl.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

endmodule

// ===== sv/cmr_dp.sv =====
// ----------------------------------------------------------------------------
// cmr_dp
// sum and mean memories, frame counter, divider and output register
// ----------------------------------------------------------------------------
module cmr_dp #(
  parameter int MAX_CHANNELS = cmr_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_FRAMES   = cmr_pkg::MAX_FRAMES_DEF,
  parameter int SAMPLE_BITS  = cmr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [cmr_pkg::CFG_W-1:0]          cfg_data,
  input  logic [cmr_pkg::CH_FIELD_W-1:0]     in_channel,
  input  logic signed [SAMPLE_BITS-1:0]      in_sample,
  output logic [cmr_pkg::CH_FIELD_W-1:0]     out_channel,
  output logic signed [SAMPLE_BITS:0]        out_corrected,
  input  cmr_pkg::ctl_t                      ctl,
  output cmr_pkg::st_t                       st
);
  import cmr_pkg::*;

  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int FC_W  = $clog2(MAX_FRAMES + 1);
  localparam int SUM_W = $clog2(MAX_FRAMES) + SAMPLE_BITS + 1;
  localparam logic signed [SUM_W:0] SUM_LIM =
    (SUM_W+1)'(MAX_FRAMES) << (SAMPLE_BITS - 1);
  localparam logic [SUM_W-1:0] POS_LIM = SUM_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic [SUM_W-1:0] NEG_LIM = SUM_W'(64'd1 << (SAMPLE_BITS - 1));

  logic signed [SUM_W-1:0]       sum_mem [MAX_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] mean_mem [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0]       sum_vld_r;
  logic [MAX_CHANNELS-1:0]       mean_vld_r;

  logic [CFG_W-1:0]              channels_r;
  logic [FC_W-1:0]               fc_r;
  logic                          frozen_r;
  logic [IDX_W-1:0]              k_r;

  logic [IDX_W-1:0]              idx_r;
  logic [CH_FIELD_W-1:0]         ch_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic signed [SUM_W-1:0]       sum_rd_r;
  logic                          sum_vld_rd_r;
  logic signed [SAMPLE_BITS-1:0] mean_rd_r;
  logic                          mean_vld_rd_r;
  logic                          neg_r;
  logic [CH_FIELD_W-1:0]         out_ch_r;
  logic signed [SAMPLE_BITS:0]   out_corr_r;

  logic [IDX_W-1:0]              in_idx;
  logic [IDX_W-1:0]              rd_idx;
  logic                          rd_en;
  logic signed [SUM_W-1:0]       sum_val;
  logic signed [SAMPLE_BITS-1:0] mean_val;
  logic signed [SUM_W:0]         sum_new;
  logic signed [SUM_W:0]         sum_sat;
  logic [SUM_W-1:0]              sum_mag;
  logic                          div_done;
  logic [SUM_W-1:0]              quo;
  logic [SUM_W-1:0]              lim;
  logic [SUM_W-1:0]              mag;
  logic [SAMPLE_BITS-1:0]        mag_s;
  logic signed [SAMPLE_BITS-1:0] mean_new;

  assign in_idx = IDX_W'(in_channel);
  assign rd_idx = ctl.fin_rd ? k_r : in_idx;
  assign rd_en  = ctl.accept | ctl.fin_rd;

  assign st.in_active = (CFG_W'(in_channel) < channels_r) &&
                        (32'(in_channel) < MAX_CHANNELS);
  assign st.frozen    = frozen_r;
  assign st.fc_full   = fc_r >= FC_W'(MAX_FRAMES);
  assign st.ch_zero   = in_channel == '0;
  assign st.div_done  = div_done;
  assign st.last_ch   = k_r == IDX_W'(MAX_CHANNELS - 1);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channels_r <= CHANNELS_RESET;
      fc_r       <= '0;
      frozen_r   <= 1'b0;
      k_r        <= '0;
      sum_vld_r  <= '0;
      mean_vld_r <= '0;
    end else begin
      if (cfg_we) channels_r <= cfg_data;
      if (ctl.clr) begin
        fc_r      <= '0;
        frozen_r  <= 1'b0;
        sum_vld_r <= '0;
      end else begin
        if (ctl.frame_inc) fc_r <= fc_r + 1'b1;
        if (ctl.freeze) frozen_r <= 1'b1;
        if (ctl.acc_wr) sum_vld_r[idx_r] <= 1'b1;
      end
      if (ctl.mean_wr) mean_vld_r[k_r] <= 1'b1;
      if (ctl.k_clr) k_r <= '0;
      else if (ctl.k_inc) k_r <= k_r + 1'b1;
    end
  end

  // item capture and memory reads
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      idx_r    <= in_idx;
      ch_r     <= in_channel;
      sample_r <= in_sample;
    end
    if (rd_en) begin
      sum_rd_r      <= sum_mem[rd_idx];
      sum_vld_rd_r  <= sum_vld_r[rd_idx];
      mean_rd_r     <= mean_mem[rd_idx];
      mean_vld_rd_r <= mean_vld_r[rd_idx];
    end
  end

  assign sum_val  = sum_vld_rd_r ? sum_rd_r : '0;
  assign mean_val = mean_vld_rd_r ? mean_rd_r : '0;

  // saturating accumulate
  always_comb begin
    sum_new = (SUM_W+1)'(sum_val) + (SUM_W+1)'(sample_r);
    if (sum_new > SUM_LIM) sum_sat = SUM_LIM;
    else if (sum_new < -SUM_LIM) sum_sat = -SUM_LIM;
    else sum_sat = sum_new;
  end

  always_ff @(posedge clk) begin
    if (ctl.acc_wr) sum_mem[idx_r] <= sum_sat[SUM_W-1:0];
  end

  // mean by division of the magnitude
  assign sum_mag = sum_val[SUM_W-1] ? SUM_W'(-sum_val) : SUM_W'(sum_val);

  always_ff @(posedge clk) begin
    if (ctl.div_start) neg_r <= sum_val[SUM_W-1];
  end

  cmr_div #(
    .NUM_W (SUM_W),
    .DEN_W (FC_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.div_start),
    .num   (sum_mag),
    .den   (fc_r),
    .done  (div_done),
    .quo   (quo)
  );

  always_comb begin
    lim   = neg_r ? NEG_LIM : POS_LIM;
    mag   = (quo > lim) ? lim : quo;
    mag_s = mag[SAMPLE_BITS-1:0];
    if (fc_r == '0) mean_new = '0;
    else if (neg_r) mean_new = -$signed(mag_s);
    else mean_new = $signed(mag_s);
  end

  always_ff @(posedge clk) begin
    if (ctl.mean_wr) mean_mem[k_r] <= mean_new;
  end

  // output register
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_ch_r   <= ch_r;
      out_corr_r <= (SAMPLE_BITS+1)'(sample_r) - (SAMPLE_BITS+1)'(mean_val);
    end
  end

  assign out_channel   = out_ch_r;
  assign out_corrected = out_corr_r;

endmodule

// ===== sv/channel_mean_removal_top.sv =====
// ----------------------------------------------------------------------------
// channel_mean_removal_top
// per-channel mean removal over a multi-channel sample stream
// ----------------------------------------------------------------------------
// clear acts on accept; accumulate reads the sum on accept and writes it in S_ACC;
//   remove mean loads the output register in S_SUB; finish means runs S_FRD,
//   S_FSTART and S_FDIV per channel on the bit-per-cycle divider, SUM_W =
//   log2(MAX_FRAMES) + SAMPLE_BITS + 1; one item in flight at a time; a waiting
//   result holds a later remove-mean item until out_ready
// reset: sums and means cleared through valid bits, frame count zeroed, no sweep
module channel_mean_removal_top #(
  parameter int MAX_CHANNELS = cmr_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_FRAMES   = cmr_pkg::MAX_FRAMES_DEF,
  parameter int SAMPLE_BITS  = cmr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [cmr_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [cmr_pkg::CMD_W-1:0]          in_cmd,
  input  logic [cmr_pkg::CH_FIELD_W-1:0]     in_channel,
  input  logic signed [SAMPLE_BITS-1:0]      in_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [cmr_pkg::CH_FIELD_W-1:0]     out_channel,
  output logic signed [SAMPLE_BITS:0]        out_corrected
);
  import cmr_pkg::*;

  ctl_t ctl;
  st_t  st;

  cmr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .st        (st),
    .ctl       (ctl)
  );

  cmr_dp #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_FRAMES   (MAX_FRAMES),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_channel    (in_channel),
    .in_sample     (in_sample),
    .out_channel   (out_channel),
    .out_corrected (out_corrected),
    .ctl           (ctl),
    .st            (st)
  );

  a_frame_limit: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.frame_inc |-> !st.fc_full)
    else $error("frame count stepped past its limit");

  a_acc_follows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.acc_wr |-> $past(ctl.accept))
    else $error("sum write without a preceding accept");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> (!out_valid || out_ready))
    else $error("output register overwritten while full");

  a_mean_div: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.mean_wr |-> st.div_done)
    else $error("mean written before divider finished");

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for channel mean removal: a queue-fed driver pushes
// clear, accumulate, finish and remove-mean items under random gaps, a clocked
// monitor predicts each accepted item and checks every corrected sample
// ----------------------------------------------------------------------------
module tb_top;
  import cmr_pkg::*;

  localparam int     MAX_CH      = 64;
  localparam int     MAX_FR      = 1024;
  localparam int     SBITS       = 24;
  localparam longint SUM_LIM     = longint'(MAX_FR) << (SBITS - 1);
  localparam longint SMP_MAX     = (longint'(1) << (SBITS - 1)) - 1;
  localparam longint SMP_MIN     = -SMP_MAX - 1;
  localparam int     SETTLE      = 2500;
  localparam int     CYCLE_LIMIT = 4000000;

  typedef struct {
    cmd_t                    cmd;
    logic [CH_FIELD_W-1:0]   channel;
    logic signed [SBITS-1:0] sample;
  } sample_item_t;

  typedef struct {
    logic [CH_FIELD_W-1:0] channel;
    logic signed [SBITS:0] corrected;
  } corrected_t;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    cfg_we     = 1'b0;
  logic [CFG_W-1:0]        cfg_data   = '0;
  logic                    in_valid   = 1'b0;
  logic                    in_ready;
  logic [CMD_W-1:0]        in_cmd     = '0;
  logic [CH_FIELD_W-1:0]   in_channel = '0;
  logic signed [SBITS-1:0] in_sample  = '0;
  logic                    out_valid;
  logic                    out_ready  = 1'b0;
  logic [CH_FIELD_W-1:0]   out_channel;
  logic signed [SBITS:0]   out_corrected;

  channel_mean_removal_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_channel   (in_channel),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_channel  (out_channel),
    .out_corrected(out_corrected)
  );

  always #1 clk = ~clk;

  // predicted block state
  longint                  chan_sum  [MAX_CH];
  logic signed [SBITS-1:0] chan_mean [MAX_CH];
  int unsigned             frames;
  bit                      frozen;
  logic [CFG_W-1:0]        chan_reg;

  sample_item_t stim_q [$];
  corrected_t   corrected_q [$];

  int n_pushed    = 0;
  int n_driven    = 0;
  int n_accepted  = 0;
  int n_results   = 0;
  int n_errors    = 0;
  int n_finish    = 0;
  int n_freeze    = 0;
  int n_settings  = 0;
  int cycles      = 0;
  int in_gap      = 0;
  int out_stall   = 0;
  int in_gap_pct  = 0;
  int out_gap_pct = 0;

  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(60, 20);
    return $urandom_range(3, 1);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(3))
      0: return 0;
      1: return 5;
      2: return 25;
      default: return 60;
    endcase
  endfunction

  function automatic logic signed [SBITS-1:0] rand_sample();
    case ($urandom_range(7))
      0: return SBITS'(SMP_MAX);
      1: return SBITS'(SMP_MIN);
      2: return SBITS'(int'($urandom_range(255)) - 128);
      default: return SBITS'($urandom());
    endcase
  endfunction

  task automatic note_error(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("ERROR: %s", msg);
  endtask

  task automatic mean_model_item(input cmd_t cmd, input logic [CH_FIELD_W-1:0] ch,
                                 input logic signed [SBITS-1:0] s);
    int unsigned active;
    bit          live;
    longint      acc;
    corrected_t  r;
    active = (chan_reg < MAX_CH) ? chan_reg : MAX_CH;
    live   = ch < active;
    case (cmd)
      CMD_CLEAR: begin
        foreach (chan_sum[k]) chan_sum[k] = 0;
        frames = 0;
        frozen = 1'b0;
      end
      CMD_ACC: if (live && !frozen) begin
        if (ch == 0 && frames >= MAX_FR) begin
          frozen = 1'b1;
          n_freeze++;
        end else begin
          if (ch == 0) frames++;
          acc = chan_sum[ch] + longint'(s);
          chan_sum[ch] = (acc > SUM_LIM) ? SUM_LIM : (acc < -SUM_LIM) ? -SUM_LIM : acc;
        end
      end
      CMD_FINISH: begin
        n_finish++;
        foreach (chan_mean[k]) begin
          if (frames == 0) begin
            chan_mean[k] = '0;
          end else begin
            // integer division truncates toward zero
            acc = chan_sum[k] / longint'(frames);
            acc = (acc > SMP_MAX) ? SMP_MAX : (acc < SMP_MIN) ? SMP_MIN : acc;
            chan_mean[k] = acc[SBITS-1:0];
          end
        end
      end
      default: if (live) begin
        acc = longint'(s) - longint'(chan_mean[ch]);
        r.channel   = ch;
        r.corrected = acc[SBITS:0];
        corrected_q.push_back(r);
      end
    endcase
  endtask

  // monitor: predict on accept, check on result
  always @(posedge clk) begin
    corrected_t want;
    if (!rst_n) begin
      foreach (chan_sum[k]) chan_sum[k] = 0;
      foreach (chan_mean[k]) chan_mean[k] = '0;
      frames   = 0;
      frozen   = 1'b0;
      chan_reg = CHANNELS_RESET;
    end else begin
      if (cfg_we) chan_reg = cfg_data;
      if (out_valid && out_ready) begin
        n_results++;
        if (corrected_q.size() == 0) begin
          note_error($sformatf("result with nothing expected: ch %0d corrected %0d",
                               out_channel, out_corrected));
        end else begin
          want = corrected_q.pop_front();
          if (out_channel !== want.channel || out_corrected !== want.corrected)
            note_error($sformatf("expected ch %0d corrected %0d, got ch %0d corrected %0d",
                                 want.channel, want.corrected, out_channel, out_corrected));
        end
      end
      if (in_valid && in_ready) begin
        mean_model_item(cmd_t'(in_cmd), in_channel, in_sample);
        n_accepted <= n_accepted + 1;
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    sample_item_t it;
    if (n_driven == n_accepted) begin
      if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (stim_q.size() > 0) begin
        it = stim_q.pop_front();
        in_cmd     <= it.cmd;
        in_channel <= it.channel;
        in_sample  <= it.sample;
        in_valid   <= 1'b1;
        n_driven   <= n_driven + 1;
        in_gap     <= pick_gap(in_gap_pct);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_stall <= pick_gap(out_gap_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_item(input cmd_t c, input int ch, input logic signed [SBITS-1:0] s);
    sample_item_t it;
    it.cmd     = c;
    it.channel = ch[CH_FIELD_W-1:0];
    it.sample  = s;
    stim_q.push_back(it);
    n_pushed++;
  endtask

  task automatic push_noise();
    int   r;
    cmd_t c;
    r = $urandom_range(9);
    c = (r == 0) ? CMD_CLEAR : (r == 1) ? CMD_FINISH : (r < 6) ? CMD_ACC : CMD_REMOVE;
    push_item(c, $urandom_range(63), rand_sample());
  endtask

  function automatic int pick_channel(input int active);
    if (active == 0 || $urandom_range(7) == 0) return $urandom_range(63);
    return $urandom_range(active - 1);
  endfunction

  // clear, whole frames in channel order with occasional noise items, finish, then remove-mean items
  task automatic run_sequence(input int active);
    int nfr;
    nfr = $urandom_range((active <= 8) ? 6 : 2, 1);
    push_item(CMD_CLEAR, $urandom_range(63), rand_sample());
    for (int f = 0; f < nfr; f++) begin
      for (int c = 0; c < active; c++) begin
        if ($urandom_range(19) == 0) push_noise();
        push_item(CMD_ACC, c, rand_sample());
      end
    end
    push_item(CMD_FINISH, $urandom_range(63), rand_sample());
    repeat (active + 2) push_item(CMD_REMOVE, pick_channel(active), rand_sample());
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (stim_q.size() != 0 || n_driven != n_accepted || corrected_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_channels(input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
    n_settings++;
  endtask

  task automatic random_phase(input logic [CFG_W-1:0] v, input int budget);
    int stop_at;
    int active;
    wait_idle();
    in_gap_pct  = pick_pct();
    out_gap_pct = pick_pct();
    write_channels(v);
    active  = (v < MAX_CH) ? v : MAX_CH;
    stop_at = n_pushed + budget;
    while (n_pushed < stop_at) begin
      if ($urandom_range(4) == 0) push_noise();
      else run_sequence(active);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] plan [6];
    plan = '{7'd1, 7'd127, 7'd0, 7'd2, 7'd5, 7'd0};
    plan[5] = CFG_W'($urandom_range(12, 3));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset means, empty finish, truncation toward zero, clear keeps means
    in_gap_pct  = 25;
    out_gap_pct = 25;
    push_item(CMD_REMOVE, 0, SBITS'(SMP_MAX));
    push_item(CMD_REMOVE, 63, SBITS'(SMP_MIN));
    push_item(CMD_FINISH, 0, '0);
    push_item(CMD_REMOVE, 1, -24'sd1);
    push_item(CMD_ACC, 0, SBITS'(SMP_MAX));
    push_item(CMD_ACC, 5, 24'sd7);
    push_item(CMD_ACC, 7, -24'sd7);
    push_item(CMD_ACC, 63, SBITS'(SMP_MIN));
    push_item(CMD_ACC, 0, SBITS'(SMP_MIN));
    push_item(CMD_ACC, 5, -24'sd2);
    push_item(CMD_ACC, 7, 24'sd2);
    push_item(CMD_ACC, 63, SBITS'(SMP_MAX));
    push_item(CMD_FINISH, 0, '0);
    push_item(CMD_REMOVE, 0, '0);
    push_item(CMD_REMOVE, 5, SBITS'(SMP_MIN));
    push_item(CMD_REMOVE, 7, SBITS'(SMP_MAX));
    push_item(CMD_REMOVE, 63, SBITS'(SMP_MAX));
    push_item(CMD_REMOVE, 2, 24'sd9);
    push_item(CMD_CLEAR, 0, '0);
    push_item(CMD_REMOVE, 5, 24'sd5);
    push_item(CMD_FINISH, 0, '0);
    push_item(CMD_REMOVE, 5, 24'sd5);

    // directed: inactive channels
    wait_idle();
    write_channels(7'd4);
    push_item(CMD_ACC, 10, 24'sd1000);
    push_item(CMD_ACC, 0, 24'sd100);
    push_item(CMD_ACC, 3, -24'sd100);
    push_item(CMD_REMOVE, 10, 24'sd1);
    push_item(CMD_REMOVE, 4, 24'sd1);
    push_item(CMD_FINISH, 0, '0);
    push_item(CMD_REMOVE, 3, '0);

    // mean saturation over one frame, then the frame limit with the sum at its bound
    wait_idle();
    in_gap_pct  = 5;
    out_gap_pct = 5;
    write_channels(7'd3);
    push_item(CMD_CLEAR, 0, '0);
    push_item(CMD_ACC, 0, rand_sample());
    repeat (3) begin
      push_item(CMD_ACC, 1, SBITS'(SMP_MAX));
      push_item(CMD_ACC, 2, SBITS'(SMP_MIN));
    end
    push_item(CMD_FINISH, 0, '0);
    push_item(CMD_REMOVE, 1, SBITS'(SMP_MIN));
    push_item(CMD_REMOVE, 1, SBITS'(SMP_MAX));
    push_item(CMD_REMOVE, 2, SBITS'(SMP_MAX));
    push_item(CMD_REMOVE, 2, SBITS'(SMP_MIN));
    push_item(CMD_CLEAR, 0, '0);
    repeat (MAX_FR + 2) push_item(CMD_ACC, 0, SBITS'(SMP_MIN));
    push_item(CMD_ACC, 1, SBITS'(SMP_MIN));
    push_item(CMD_ACC, 2, SBITS'(SMP_MAX));
    push_item(CMD_FINISH, 0, '0);
    for (int c = 0; c < 3; c++) push_item(CMD_REMOVE, c, rand_sample());
    push_item(CMD_CLEAR, 0, '0);
    for (int c = 0; c < 3; c++) push_item(CMD_ACC, c, rand_sample());
    push_item(CMD_FINISH, 0, '0);
    for (int c = 0; c < 3; c++) push_item(CMD_REMOVE, c, rand_sample());

    foreach (plan[i]) random_phase(plan[i], 20);
    wait_idle();

    $display("ran %0d items under %0d channel settings, %0d corrected samples checked",
             n_accepted, n_settings, n_results);
    $display("finish commands %0d, frame limit hits %0d, mismatches %0d",
             n_finish, n_freeze, n_errors);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/cmr_pkg.sv
sv/cmr_div.sv
sv/cmr_ctrl.sv
sv/cmr_dp.sv
sv/channel_mean_removal_top.sv
bench/tb_top.sv
